### src/roca_pkg.sv
// Package for the rate-of-change averager: command/status structs, controller
// states, register indexes and fixed field widths.
// No dependencies; used by every module of the block but roca_div, and by the testbench.
`timescale 1ns / 1ps

package roca_pkg;

	// fixed field widths
	localparam int SAMPLE_W  = 16;
	localparam int ELAPSED_W = 16;
	localparam int RATE_W    = 16;
	localparam int INST_W    = 26;
	localparam int SCALE_W   = 10;
	localparam int PDIV_W    = 5;
	localparam int CFG_IDX_W = 1;

	// register indexes on the configuration channel
	localparam logic [CFG_IDX_W-1:0] REG_RATE_SCALE = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_POST_DIV   = 1'b1;

	// register reset values
	localparam logic [SCALE_W-1:0] RATE_SCALE_RST = 10'd100;
	localparam logic [PDIV_W-1:0]  POST_DIV_RST   = 5'd10;

	// operand selection for the shared divider
	typedef enum logic {
		DSEL_RATE = 1'b0,  // scaled difference / elapsed time
		DSEL_MEAN = 1'b1   // window total / (WINDOW * post divisor)
	} roca_dsel_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_MUL,
		S_DIV1_GO,
		S_DIV1,
		S_DIV2_GO,
		S_DIV2,
		S_OUT
	} roca_state_t;

	// controller to datapath
	typedef struct packed {
		logic       load;
		logic       mul;
		logic       div_start;
		roca_dsel_t div_sel;
		logic       hist_upd;
		logic       out_load;
	} roca_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic div_done;
		logic out_free;
	} roca_sts_t;

endpackage

### src/rate_of_change_averager_core.sv
// One item is in work at a time: the next is taken in the cycle after the result
// enters the output register, and a result waits before that register while the
// one in it is held by m_tready. Each item makes two passes through the shared
// one-bit-per-cycle divider, whose dividend is SUM_W = 26 + clog2(WINDOW) bits
// wide. Reset (arst_n, async, active low) clears previous sample, rate history and
// running sum; rate_scale = 100, post_divisor = 10.
`timescale 1ns / 1ps

module rate_of_change_averager_core #(
	parameter int WINDOW = 5
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// configuration write channel
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [roca_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [roca_pkg::SCALE_W-1:0]   cfg_data,
	// input items
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [31:0]                    s_tdata,   // [15:0] sample, [31:16] elapsed_ms
	// result items
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [roca_pkg::RATE_W-1:0]    m_tdata    // [15:0] rate
);

	localparam int SUM_W = roca_pkg::INST_W + $clog2(WINDOW);

	roca_pkg::roca_cmd_t cmd;
	roca_pkg::roca_sts_t sts;

	// configuration writes always taken
	assign cfg_ready = 1'b1;

	roca_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.cmd      (cmd),
		.sts      (sts)
	);

	roca_dp #(
		.WINDOW (WINDOW),
		.SUM_W  (SUM_W)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

endmodule

### src/roca_div.sv
// Iterative restoring divider, one quotient bit per cycle.
// Depends on nothing; instantiated by roca_dp.
`timescale 1ns / 1ps

module roca_div #(
	parameter int DVD_W = 30,
	parameter int DVS_W = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DVD_W-1:0] dividend,
	input  logic [DVS_W-1:0] divisor,
	output logic             busy,
	output logic             done,
	output logic [DVD_W-1:0] quotient
);

	localparam int CNT_W = $clog2(DVD_W + 1);

	logic [CNT_W-1:0] cnt_q;
	logic             done_q;
	logic [DVD_W-1:0] quo_q;
	logic [DVS_W-1:0] rem_q;
	logic [DVS_W-1:0] dvs_q;

	logic [DVS_W:0]   shifted;
	logic [DVS_W+1:0] trial;
	logic             ge;

	// one restoring step: bring down the next dividend bit and try a subtract
	always_comb begin
		shifted = {rem_q, quo_q[DVD_W-1]};
		trial   = {1'b0, shifted} - {2'b00, dvs_q};
		ge      = ~trial[DVS_W+1];
	end

	// iteration counter and done pulse
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= (cnt_q == CNT_W'(1));
			if (start) begin
				cnt_q <= CNT_W'(DVD_W);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

	// remainder and quotient shift register
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (cnt_q != '0) begin
			quo_q <= {quo_q[DVD_W-2:0], ge};
			rem_q <= ge ? trial[DVS_W-1:0] : shifted[DVS_W-1:0];
		end
	end

	assign busy     = (cnt_q != '0);
	assign done     = done_q;
	assign quotient = quo_q;

endmodule

### src/roca_dp.sv
// Datapath: config registers, sample difference, scale multiply, rate history
// with running sum, shared divider and output register.
// Depends on roca_pkg and roca_div.
`timescale 1ns / 1ps

module roca_dp #(
	parameter int WINDOW = 5,
	parameter int SUM_W  = 29
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  roca_pkg::roca_cmd_t                cmd,
	output roca_pkg::roca_sts_t                sts,
	input  logic                               cfg_valid,
	input  logic [roca_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [roca_pkg::SCALE_W-1:0]       cfg_data,
	input  logic [31:0]                        s_tdata,
	output logic                               m_tvalid,
	input  logic                               m_tready,
	output logic [roca_pkg::RATE_W-1:0]        m_tdata
);

	localparam int HIST  = WINDOW - 1;
	localparam int DVS_W = roca_pkg::ELAPSED_W;
	localparam int PROD_W = roca_pkg::SAMPLE_W + roca_pkg::SCALE_W;

	logic [roca_pkg::SCALE_W-1:0]   rate_scale_q;
	logic [roca_pkg::PDIV_W-1:0]    post_div_q;
	logic [roca_pkg::SAMPLE_W-1:0]  prev_q;
	logic [roca_pkg::SAMPLE_W-1:0]  diff_q;
	logic [DVS_W-1:0]               elapsed_q;
	logic [PROD_W-1:0]              prod_q;
	logic [roca_pkg::INST_W-1:0]    hist_q [HIST];
	logic [SUM_W-1:0]               sum_q;
	logic [SUM_W-1:0]               total_q;
	logic                           out_valid_q;
	logic [roca_pkg::RATE_W-1:0]    out_q;

	logic [roca_pkg::SAMPLE_W-1:0]  in_sample;
	logic [DVS_W-1:0]               in_elapsed;
	logic [roca_pkg::PDIV_W-1:0]    pd_eff;
	logic [SUM_W-1:0]               dvd;
	logic [DVS_W-1:0]               dvs;
	logic                           div_busy;
	logic                           div_done;
	logic [SUM_W-1:0]               quo;
	logic [SUM_W-1:0]               inst_ext;
	logic [SUM_W-1:0]               oldest_ext;

	assign in_sample  = s_tdata[15:0];
	assign in_elapsed = s_tdata[31:16];

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rate_scale_q <= roca_pkg::RATE_SCALE_RST;
			post_div_q   <= roca_pkg::POST_DIV_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				roca_pkg::REG_RATE_SCALE: rate_scale_q <= cfg_data;
				roca_pkg::REG_POST_DIV:   post_div_q   <= cfg_data[roca_pkg::PDIV_W-1:0];
				default:                  ;
			endcase
		end
	end

	// previous sample, updated as the item is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q <= '0;
		end else if (cmd.load) begin
			prev_q <= in_sample;
		end
	end

	// absolute difference and elapsed time (zero counts as one)
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			diff_q    <= (in_sample >= prev_q) ? (in_sample - prev_q) : (prev_q - in_sample);
			elapsed_q <= (in_elapsed == '0) ? DVS_W'(1) : in_elapsed;
		end
		if (cmd.mul) begin
			prod_q <= diff_q * rate_scale_q;
		end
	end

	// divider operands
	always_comb begin
		pd_eff = (post_div_q == '0) ? roca_pkg::PDIV_W'(1) : post_div_q;
		unique case (cmd.div_sel)
			roca_pkg::DSEL_RATE: begin
				dvd = SUM_W'(prod_q);
				dvs = elapsed_q;
			end
			roca_pkg::DSEL_MEAN: begin
				dvd = total_q;
				dvs = DVS_W'(WINDOW) * DVS_W'(pd_eff);
			end
			default: begin
				dvd = SUM_W'(prod_q);
				dvs = elapsed_q;
			end
		endcase
	end

	roca_div #(
		.DVD_W (SUM_W),
		.DVS_W (DVS_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (dvd),
		.divisor  (dvs),
		.busy     (div_busy),
		.done     (div_done),
		.quotient (quo)
	);

	assign inst_ext   = SUM_W'(quo[roca_pkg::INST_W-1:0]);
	assign oldest_ext = SUM_W'(hist_q[HIST-1]);

	// rate history shift line and running sum of its entries
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < HIST; i++) begin
				hist_q[i] <= '0;
			end
			sum_q <= '0;
		end else if (cmd.hist_upd) begin
			hist_q[0] <= quo[roca_pkg::INST_W-1:0];
			for (int i = 1; i < HIST; i++) begin
				hist_q[i] <= hist_q[i-1];
			end
			sum_q <= sum_q + inst_ext - oldest_ext;
		end
	end

	// window total including the new rate
	always_ff @(posedge clk) begin
		if (cmd.hist_upd) begin
			total_q <= sum_q + inst_ext;
		end
	end

	// output register, saturated to 16 bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_q <= (|quo[SUM_W-1:roca_pkg::RATE_W]) ? '1 : quo[roca_pkg::RATE_W-1:0];
		end
	end

	assign sts.div_done = div_done;
	assign sts.out_free = ~out_valid_q | m_tready;
	assign m_tvalid     = out_valid_q;
	assign m_tdata      = out_q;

	// checks
	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_start |-> !div_busy)
		else $error("divider started while busy");
	a_out_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!out_valid_q || m_tready))
		else $error("output register overwritten before it was taken");
	a_out_rise: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(cmd.out_load))
		else $error("result shown without an output load");
	a_hist_after_div: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.hist_upd |-> div_done)
		else $error("history updated without a finished rate division");

endmodule

### src/roca_ctrl.sv
// Controller state machine sequencing one item through the datapath.
// Depends on roca_pkg.
`timescale 1ns / 1ps

module roca_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	output roca_pkg::roca_cmd_t cmd,
	input  roca_pkg::roca_sts_t sts
);

	roca_pkg::roca_state_t state_q, state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= roca_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d       = state_q;
		cmd           = '0;
		cmd.div_sel   = roca_pkg::DSEL_RATE;
		s_tready      = 1'b0;
		unique case (state_q)
			roca_pkg::S_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.load = 1'b1;
					state_d  = roca_pkg::S_MUL;
				end
			end
			roca_pkg::S_MUL: begin
				cmd.mul = 1'b1;
				state_d = roca_pkg::S_DIV1_GO;
			end
			roca_pkg::S_DIV1_GO: begin
				cmd.div_start = 1'b1;
				cmd.div_sel   = roca_pkg::DSEL_RATE;
				state_d       = roca_pkg::S_DIV1;
			end
			roca_pkg::S_DIV1: begin
				if (sts.div_done) begin
					cmd.hist_upd = 1'b1;
					state_d      = roca_pkg::S_DIV2_GO;
				end
			end
			roca_pkg::S_DIV2_GO: begin
				cmd.div_start = 1'b1;
				cmd.div_sel   = roca_pkg::DSEL_MEAN;
				state_d       = roca_pkg::S_DIV2;
			end
			roca_pkg::S_DIV2: begin
				if (sts.div_done) begin
					state_d = roca_pkg::S_OUT;
				end
			end
			roca_pkg::S_OUT: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = roca_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = roca_pkg::S_IDLE;
			end
		endcase
	end

endmodule

### tb/roca_rate_monitor.sv
// Result monitor for the rate-of-change averager: watches the configuration,
// input and result channels, predicts each rate and compares it on arrival.
// Depends on roca_pkg for field widths, register indexes and reset values.
`timescale 1ns / 1ps

module roca_rate_monitor #(
	parameter int WINDOW = 5
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	input  logic                           cfg_ready,
	input  logic [roca_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [roca_pkg::SCALE_W-1:0]   cfg_data,
	input  logic                           s_tvalid,
	input  logic                           s_tready,
	input  logic [31:0]                    s_tdata,   // [15:0] sample, [31:16] elapsed_ms
	input  logic                           m_tvalid,
	input  logic                           m_tready,
	input  logic [roca_pkg::RATE_W-1:0]    m_tdata,   // [15:0] rate
	output int                             rates_owed,
	output int                             mismatches
);

	localparam int HIST_N = WINDOW - 1;

	// shadow of the block's registers and history
	logic [roca_pkg::SCALE_W-1:0]  scale_q;
	logic [roca_pkg::PDIV_W-1:0]   pdiv_q;
	logic [roca_pkg::SAMPLE_W-1:0] last_sample;
	logic [roca_pkg::INST_W-1:0]   hist [HIST_N];
	logic [roca_pkg::RATE_W-1:0]   pending_rates [$];
	int                            n_bad = 0;

	assign mismatches = n_bad;

	// next averaged rate for one item; advances the sample and rate history
	function automatic logic [roca_pkg::RATE_W-1:0] advance_rate(
			input logic [roca_pkg::SAMPLE_W-1:0]  smp,
			input logic [roca_pkg::ELAPSED_W-1:0] dt);
		logic [63:0] delta, per, inst, total, avg, div;
		delta = (smp >= last_sample) ? 64'(smp - last_sample) : 64'(last_sample - smp);
		per = (dt == '0) ? 64'd1 : 64'(dt);
		inst = (delta * 64'(scale_q)) / per;
		inst = 64'(inst[roca_pkg::INST_W-1:0]);
		total = inst;
		for (int i = 0; i < HIST_N; i++)
			total += 64'(hist[i]);
		avg = total / 64'(WINDOW);
		for (int i = HIST_N - 1; i > 0; i--)
			hist[i] = hist[i-1];
		hist[0] = inst[roca_pkg::INST_W-1:0];
		last_sample = smp;
		div = (pdiv_q == '0) ? 64'd1 : 64'(pdiv_q);
		avg = avg / div;
		return (avg > 64'hFFFF) ? '1 : avg[roca_pkg::RATE_W-1:0];
	endfunction

	// sample all three channels on the clock edge
	always @(posedge clk or negedge arst_n) begin : watch
		logic [roca_pkg::RATE_W-1:0] want;
		int pushed, popped;
		if (!arst_n) begin
			scale_q = roca_pkg::RATE_SCALE_RST;
			pdiv_q = roca_pkg::POST_DIV_RST;
			last_sample = '0;
			for (int i = 0; i < HIST_N; i++)
				hist[i] = '0;
			pending_rates.delete();
			rates_owed <= 0;
		end else begin
			pushed = 0;
			popped = 0;
			if (m_tvalid && m_tready) begin
				if (pending_rates.size() == 0) begin
					n_bad++;
					$error("rate: no item expected, actual %0d", m_tdata);
				end else begin
					want = pending_rates.pop_front();
					popped = 1;
					if (m_tdata !== want) begin
						n_bad++;
						$error("rate: expected %0d, actual %0d", want, m_tdata);
					end
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					roca_pkg::REG_RATE_SCALE: scale_q = cfg_data;
					roca_pkg::REG_POST_DIV:   pdiv_q = cfg_data[roca_pkg::PDIV_W-1:0];
					default:                  ;
				endcase
			end
			if (s_tvalid && s_tready) begin
				pending_rates.push_back(advance_rate(s_tdata[roca_pkg::SAMPLE_W-1:0],
					s_tdata[roca_pkg::SAMPLE_W +: roca_pkg::ELAPSED_W]));
				pushed = 1;
			end
			rates_owed <= rates_owed + pushed - popped;
		end
	end

endmodule

### tb/tb_rate_of_change_averager_core.sv
// Testbench top for rate_of_change_averager_core: clock, reset, configuration
// writes, input items and result back-pressure; verdict from roca_rate_monitor.
// Depends on roca_pkg, the core and tb/roca_rate_monitor.sv.
`timescale 1ns / 1ps

module tb_rate_of_change_averager_core;

	localparam int WINDOW        = 5;
	localparam int RUN_LIMIT     = 500000;
	localparam int PHASES        = 11;
	localparam int PHASE_ITEMS   = 100;
	localparam int HOLD_CYCLES   = 400;
	localparam int SETTLE_CYCLES = 80;

	logic                           clk = 1'b0;
	logic                           arst_n = 1'b0;
	logic                           cfg_valid = 1'b0;
	logic                           cfg_ready;
	logic [roca_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [roca_pkg::SCALE_W-1:0]   cfg_data = '0;
	logic                           s_tvalid = 1'b0;
	logic                           s_tready;
	logic [31:0]                    s_tdata = '0;
	logic                           m_tvalid;
	logic                           m_tready = 1'b0;
	logic [roca_pkg::RATE_W-1:0]    m_tdata;

	int                             rates_owed;
	int                             mismatches;
	int                             cycle_count = 0;
	bit                             tx_steady = 1'b0;   // sender never idles
	bit                             rx_steady = 1'b0;   // receiver stalls only on a hold request
	bit                             rx_hold_req = 1'b0; // one long receiver stall
	logic [roca_pkg::SAMPLE_W-1:0]  last_sent = '0;

	always #10 clk = ~clk;

	rate_of_change_averager_core #(
		.WINDOW (WINDOW)
	) u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	roca_rate_monitor #(
		.WINDOW (WINDOW)
	) u_monitor (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.rates_owed (rates_owed),
		.mismatches (mismatches)
	);

	// run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == RUN_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	// result side: random stalls, now and then a long hold-off
	initial begin : result_sink
		int stall;
		@(posedge arst_n);
		forever begin
			stall = rx_steady ? 0 : $urandom_range(0, 11);
			if (rx_hold_req) begin
				rx_hold_req = 1'b0;
				stall = HOLD_CYCLES;
			end
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
		end
	end

	// offer one item after a random gap; tvalid stays high if the next gap is zero
	task automatic send_item(input logic [roca_pkg::SAMPLE_W-1:0] smp,
			input logic [roca_pkg::ELAPSED_W-1:0] dt);
		int gap;
		gap = tx_steady ? 0 : $urandom_range(0, 11);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {dt, smp};
		do @(posedge clk); while (!s_tready);
		last_sent = smp;
	endtask

	// stop offering and wait until every predicted rate has come back
	task automatic wait_idle();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (rates_owed != 0);
		repeat (2) @(posedge clk);
	endtask

	// one register write; valid is left high for a following write
	task automatic write_reg(input logic [roca_pkg::CFG_IDX_W-1:0] idx,
			input logic [roca_pkg::SCALE_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
	endtask

	// both registers; unused upper bits of the divisor write carry noise
	task automatic set_config(input logic [roca_pkg::SCALE_W-1:0] scale,
			input logic [roca_pkg::PDIV_W-1:0] pdiv);
		write_reg(roca_pkg::REG_RATE_SCALE, scale);
		write_reg(roca_pkg::REG_POST_DIV, {5'($urandom_range(0, 31)), pdiv});
		cfg_valid <= 1'b0;
	endtask

	initial begin : stimulus
		int phase, n;
		logic [roca_pkg::SCALE_W-1:0]   scale;
		logic [roca_pkg::PDIV_W-1:0]    pdiv;
		logic [roca_pkg::SAMPLE_W-1:0]  smp;
		logic [roca_pkg::ELAPSED_W-1:0] dt;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: first samples, zero elapsed time, saturation
		send_item(16'd0, 16'd0);
		send_item(16'hFFFF, 16'd0);
		send_item(16'd0, 16'hFFFF);
		send_item(16'hFFFF, 16'hFFFF);
		send_item(16'd1, 16'd1);
		send_item(16'd40000, 16'd3);

		// widest scale, divisor one: largest instantaneous rate
		wait_idle();
		set_config(10'd1023, 5'd1);
		send_item(16'd0, 16'd1);
		send_item(16'hFFFF, 16'd1);
		send_item(16'd0, 16'd0);
		send_item(16'hFFFF, 16'd2);

		// zero scale and zero divisor
		wait_idle();
		set_config(10'd0, 5'd0);
		send_item(16'd100, 16'd5);
		send_item(16'd60000, 16'd0);

		// acceleration scale with a divisor above sixteen
		wait_idle();
		set_config(10'd1000, 5'd31);
		send_item(16'd0, 16'd1000);
		send_item(16'hFFFF, 16'd1);
		send_item(16'd32768, 16'd0);

		// random phases, each under its own settings
		for (phase = 0; phase < PHASES; phase++) begin
			wait_idle();
			case ($urandom_range(0, 5))
				0: scale = 10'd0;
				1: scale = 10'd1;
				2: scale = 10'd100;
				3: scale = 10'd1000;
				4: scale = 10'd1023;
				default: scale = 10'($urandom_range(0, 1023));
			endcase
			case ($urandom_range(0, 5))
				0: pdiv = 5'd0;
				1: pdiv = 5'd1;
				2: pdiv = 5'd10;
				3: pdiv = 5'd16;
				4: pdiv = 5'd31;
				default: pdiv = 5'($urandom_range(0, 31));
			endcase
			set_config(scale, pdiv);
			tx_steady = ($urandom_range(0, 3) == 0);
			rx_steady = ($urandom_range(0, 3) == 0);
			// back-to-back items against a stalled result side
			if (phase == 2 || phase == 7) begin
				tx_steady = 1'b1;
				rx_hold_req = 1'b1;
			end
			for (n = 0; n < PHASE_ITEMS; n++) begin
				// mostly readings near the last one, as a real sensor gives
				case ($urandom_range(0, 5))
					0: smp = 16'($urandom_range(0, 65535));
					1: smp = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
					default: smp = last_sent + 16'($urandom_range(0, 4000)) - 16'd2000;
				endcase
				case ($urandom_range(0, 6))
					0: dt = 16'd0;
					1: dt = 16'hFFFF;
					2: dt = 16'($urandom_range(0, 65535));
					3: dt = 16'd1;
					default: dt = 16'($urandom_range(1, 100));
				endcase
				send_item(smp, dt);
			end
		end

		wait_idle();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0 && rates_owed == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule

### sim.f
src/roca_pkg.sv
src/roca_div.sv
src/roca_dp.sv
src/roca_ctrl.sv
src/rate_of_change_averager_core.sv
tb/roca_rate_monitor.sv
tb/tb_rate_of_change_averager_core.sv
